### sv/separable_blur_decimate_by_two_assert.svh
// Assertion macros for the blur and decimate block.
// Used by the top level only; needs no package.
`ifndef SEPARABLE_BLUR_DECIMATE_BY_TWO_ASSERT_SVH
`define SEPARABLE_BLUR_DECIMATE_BY_TWO_ASSERT_SVH

// Same-cycle implication, checked at every rising clock edge outside reset.
`define SBD_ASSERT_IMPLY(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sbd assertion failed");

// Next-cycle implication, checked at every rising clock edge outside reset.
`define SBD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sbd assertion failed");

`endif

### sv/sbd_pkg.sv
// Shared types and constants of the blur and decimate block.
// Used by the top level and sbd_cfg; depends on nothing.
`timescale 1ns / 1ps

package sbd_pkg;

    localparam int PIX_W        = 8;
    localparam int COEF_W       = 8;
    localparam int SHIFT_W      = 4;
    localparam int GEOM_W       = 11;
    localparam int ROW_W        = 10;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_SUM_W    = 16;
    localparam int MAX_TAPS     = 5;
    localparam int IDX_W        = 3;
    localparam int PROD_W       = COEF_W + ROW_SUM_W;
    localparam int ACC_W        = PROD_W + 3;
    localparam int CFG_IDX_W    = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COEF_0       = 3'd0,
        REG_COEF_1       = 3'd1,
        REG_COEF_2       = 3'd2,
        REG_COEF_3       = 3'd3,
        REG_COEF_4       = 3'd4,
        REG_NORM_SHIFT   = 3'd5,
        REG_FRAME_WIDTH  = 3'd6,
        REG_FRAME_HEIGHT = 3'd7
    } cfg_reg_t;

    typedef struct packed {
        logic [MAX_TAPS-1:0][COEF_W-1:0] coef;
        logic [SHIFT_W-1:0]              norm_shift;
        logic [GEOM_W-1:0]               frame_width;
        logic [GEOM_W-1:0]               frame_height;
    } cfg_t;

endpackage

### sv/sbd_cfg.sv
// Configuration register file of the blur and decimate block.
// Depends on sbd_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module sbd_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbd_pkg::GEOM_W-1:0]    cfg_data,
    output sbd_pkg::cfg_t                 cfg
);

    sbd_pkg::cfg_t cfg_reg;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.coef[0]      <= 8'd1;
            cfg_reg.coef[1]      <= 8'd4;
            cfg_reg.coef[2]      <= 8'd6;
            cfg_reg.coef[3]      <= 8'd4;
            cfg_reg.coef[4]      <= 8'd1;
            cfg_reg.norm_shift   <= 4'd4;
            cfg_reg.frame_width  <= 11'd640;
            cfg_reg.frame_height <= 11'd480;
        end else if (cfg_valid) begin
            unique case (sbd_pkg::cfg_reg_t'(cfg_index))
                sbd_pkg::REG_COEF_0:       cfg_reg.coef[0] <= cfg_data[7:0];
                sbd_pkg::REG_COEF_1:       cfg_reg.coef[1] <= cfg_data[7:0];
                sbd_pkg::REG_COEF_2:       cfg_reg.coef[2] <= cfg_data[7:0];
                sbd_pkg::REG_COEF_3:       cfg_reg.coef[3] <= cfg_data[7:0];
                sbd_pkg::REG_COEF_4:       cfg_reg.coef[4] <= cfg_data[7:0];
                sbd_pkg::REG_NORM_SHIFT:   cfg_reg.norm_shift <= cfg_data[3:0];
                sbd_pkg::REG_FRAME_WIDTH:  cfg_reg.frame_width <= cfg_data;
                sbd_pkg::REG_FRAME_HEIGHT: cfg_reg.frame_height <= cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### sv/sbd_line_store.sv
// Line store of row sums: one word per column, one 16-bit lane per stored row.
// Synchronous memory, one write and one registered read per cycle; no package needed.
`timescale 1ns / 1ps

module sbd_line_store #(
    parameter int DEPTH  = 1024,
    parameter int WORD_W = 64
) (
    input  logic                     aclk,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WORD_W-1:0]        rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WORD_W-1:0]        wr_data
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    assign rd_data = rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule

### sv/separable_blur_decimate_by_two.sv
// Separable blur and decimate by two for a raster stream of 8-bit pixels. A word
// whose column is below TAPS-1 is only shifted into the window; any other runs the
// horizontal sum, the vertical sum when it yields an output word, and a write-back
// step, which for an output word waits for a free output; no new word is taken
// meanwhile. One shared 8x16 multiplier is stepped once per tap. The line store keeps
// the row sums of the last TAPS-1 rows as one memory word per column that is read,
// updated in one lane and written back. It is never cleared, so no start-up pass is
// needed. Output size is (W-TAPS)/2+1 by (H-TAPS)/2+1; m_tlast marks the end of an
// output row. Depends on sbd_pkg, sbd_cfg, sbd_line_store and the assertion header.
`timescale 1ns / 1ps
`include "separable_blur_decimate_by_two_assert.svh"

module separable_blur_decimate_by_two #(
    parameter int TAPS      = 5,
    parameter int MAX_WIDTH = 1024
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [7:0] pixel
    input  logic                          s_tuser,   // [0] frame_start
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [7:0]                    m_tdata,   // [7:0] out_pixel
    output logic                          m_tlast,   // row_end
    output logic                          m_tuser,   // [0] frame_end
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [sbd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sbd_pkg::GEOM_W-1:0]    cfg_data
);

    localparam int LINES  = TAPS - 1;
    localparam int CNT_W  = $clog2(MAX_WIDTH);
    localparam int CW     = CNT_W + 1;
    localparam int EW     = (CW > sbd_pkg::GEOM_W) ? CW : sbd_pkg::GEOM_W;
    localparam int SLOT_W = (LINES > 1) ? $clog2(LINES) : 1;
    localparam int WORD_W = LINES * sbd_pkg::ROW_SUM_W;
    localparam int GW     = sbd_pkg::GEOM_W;
    localparam int RSW    = sbd_pkg::ROW_SUM_W;

    typedef enum logic [1:0] {S_IDLE, S_HSUM, S_VSUM, S_WB} state_t;

    sbd_pkg::cfg_t cfg;

    state_t                             state_reg;
    logic [CNT_W-1:0]                   col_reg;
    logic [sbd_pkg::ROW_W-1:0]          row_reg;
    logic [SLOT_W-1:0]                  slot_reg;
    logic [LINES-1:0][7:0]              win_reg;
    logic [TAPS-1:0][7:0]               taps_reg;
    logic [CNT_W-1:0]                   x_reg;
    logic [SLOT_W-1:0]                  wslot_reg;
    logic [SLOT_W-1:0]                  lane_reg;
    logic [sbd_pkg::IDX_W-1:0]          d_reg;
    logic                               emit_reg;
    logic                               re_reg;
    logic                               fe_reg;
    logic [RSW-1:0]                     hacc_reg;
    logic [sbd_pkg::ACC_W-1:0]          total_reg;
    logic                               m_tvalid_reg;
    logic [7:0]                         m_tdata_reg;
    logic                               m_tlast_reg;
    logic                               m_tuser_reg;

    logic [CW-1:0]                      w_eff;
    logic [GW-1:0]                      h_eff;
    logic [EW-1:0]                      fw_ext;
    logic [CW-1:0]                      last_x;
    logic [GW-1:0]                      last_y;

    logic [CNT_W-1:0]                   col0, col1, col2;
    logic [GW-1:0]                      row0, row1, row2;
    logic [SLOT_W-1:0]                  slot0, slot1, slot2;
    logic [CW-1:0]                      col_inc;
    logic                               active;
    logic                               emit;
    logic [CNT_W-1:0]                   x_cur;
    logic [GW-1:0]                      y_cur;
    logic                               re_cur;

    logic [WORD_W-1:0]                  rd_word;
    logic [WORD_W-1:0]                  wr_word;
    logic                               wr_en;
    logic [RSW-1:0]                     rs;
    logic [sbd_pkg::COEF_W-1:0]         mul_a;
    logic [RSW-1:0]                     mul_b;
    logic [sbd_pkg::PROD_W-1:0]         prod;
    logic [sbd_pkg::ACC_W-1:0]          scaled;
    logic                               last_tap;
    logic                               out_free;

    function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
        slot_inc = (s == SLOT_W'(LINES - 1)) ? '0 : s + 1'b1;
    endfunction

    sbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    sbd_line_store #(
        .DEPTH  (MAX_WIDTH),
        .WORD_W (WORD_W)
    ) u_store (
        .aclk    (aclk),
        .rd_addr (x_reg),
        .rd_data (rd_word),
        .wr_en   (wr_en),
        .wr_addr (x_reg),
        .wr_data (wr_word)
    );

    // Effective geometry: clamp width to [TAPS, MAX_WIDTH], height to [TAPS, 1024].
    always_comb begin
        fw_ext = EW'(cfg.frame_width);
        if (fw_ext < EW'(TAPS)) begin
            w_eff = CW'(TAPS);
        end else if (fw_ext > EW'(MAX_WIDTH)) begin
            w_eff = CW'(MAX_WIDTH);
        end else begin
            w_eff = CW'(fw_ext);
        end
        if (cfg.frame_height < GW'(TAPS)) begin
            h_eff = GW'(TAPS);
        end else if (cfg.frame_height > GW'(sbd_pkg::HEIGHT_LIMIT)) begin
            h_eff = GW'(sbd_pkg::HEIGHT_LIMIT);
        end else begin
            h_eff = cfg.frame_height;
        end
        last_x = (w_eff - CW'(TAPS)) & ~CW'(1);
        last_y = (h_eff - GW'(TAPS)) & ~GW'(1);
    end

    // Position of the incoming word and the position that follows it.
    always_comb begin
        col0  = s_tuser ? '0 : col_reg;
        row0  = s_tuser ? '0 : GW'(row_reg);
        slot0 = s_tuser ? '0 : slot_reg;
        col1  = col0;
        row1  = row0;
        slot1 = slot0;
        if (CW'(col0) >= w_eff) begin
            col1  = '0;
            row1  = row0 + 1'b1;
            slot1 = slot_inc(slot0);
        end
        if (row1 >= h_eff) begin
            row1  = '0;
            slot1 = '0;
        end
        active = (col1 >= CNT_W'(LINES));
        x_cur  = col1 - CNT_W'(LINES);
        y_cur  = row1 - GW'(LINES);
        emit   = active && (row1 >= GW'(LINES)) && !x_cur[0] && !y_cur[0];
        re_cur = (CW'(x_cur) == last_x);

        col_inc = CW'(col1) + 1'b1;
        col2    = col_inc[CNT_W-1:0];
        row2    = row1;
        slot2   = slot1;
        if (col_inc >= w_eff) begin
            col2  = '0;
            row2  = row1 + 1'b1;
            slot2 = slot_inc(slot1);
            if (row2 >= h_eff) begin
                row2  = '0;
                slot2 = '0;
            end
        end
    end

    // One shared multiplier: pixel taps first, then stored row sums and the new row sum.
    always_comb begin
        rs       = (d_reg == sbd_pkg::IDX_W'(TAPS - 1)) ? hacc_reg
                                                        : rd_word[lane_reg * RSW +: RSW];
        mul_a    = cfg.coef[d_reg];
        mul_b    = (state_reg == S_HSUM) ? RSW'(taps_reg[0]) : rs;
        prod     = sbd_pkg::PROD_W'(mul_a) * sbd_pkg::PROD_W'(mul_b);
        scaled   = sbd_pkg::ACC_W'(prod >> cfg.norm_shift);
        last_tap = (d_reg == sbd_pkg::IDX_W'(TAPS - 1));
        out_free = !m_tvalid_reg || m_tready;
    end

    // Write-back word: the lane of the current row takes the new row sum.
    always_comb begin
        wr_word = rd_word;
        for (int i = 0; i < LINES; i++) begin
            if (wslot_reg == SLOT_W'(i)) begin
                wr_word[i * RSW +: RSW] = hacc_reg;
            end
        end
        wr_en = (state_reg == S_WB) && (!emit_reg || out_free);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            col_reg      <= '0;
            row_reg      <= '0;
            slot_reg     <= '0;
            win_reg      <= '0;
            d_reg        <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        for (int d = 0; d < LINES; d++) begin
                            taps_reg[d] <= win_reg[LINES - 1 - d];
                        end
                        taps_reg[LINES] <= s_tdata;
                        for (int k = LINES - 1; k > 0; k--) begin
                            win_reg[k] <= win_reg[k - 1];
                        end
                        win_reg[0] <= s_tdata;
                        col_reg    <= col2;
                        row_reg    <= row2[sbd_pkg::ROW_W-1:0];
                        slot_reg   <= slot2;
                        x_reg      <= x_cur;
                        wslot_reg  <= slot1;
                        emit_reg   <= emit;
                        re_reg     <= re_cur;
                        fe_reg     <= re_cur && (y_cur == last_y);
                        hacc_reg   <= '0;
                        total_reg  <= '0;
                        d_reg      <= '0;
                        if (active) begin
                            state_reg <= S_HSUM;
                        end
                    end
                end
                S_HSUM: begin
                    hacc_reg <= hacc_reg + prod[RSW-1:0];
                    taps_reg <= taps_reg >> 8;
                    if (last_tap) begin
                        d_reg     <= '0;
                        lane_reg  <= wslot_reg;
                        state_reg <= emit_reg ? S_VSUM : S_WB;
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                S_VSUM: begin
                    total_reg <= total_reg + scaled;
                    lane_reg  <= slot_inc(lane_reg);
                    if (last_tap) begin
                        d_reg     <= '0;
                        state_reg <= S_WB;
                    end else begin
                        d_reg <= d_reg + 1'b1;
                    end
                end
                S_WB: begin
                    if (!emit_reg) begin
                        state_reg <= S_IDLE;
                    end else if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= 8'(total_reg >> cfg.norm_shift);
                        m_tlast_reg  <= re_reg;
                        m_tuser_reg  <= fe_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    // A new output word only ever comes out of the write-back step of an emitting item.
    `SBD_ASSERT_IMPLY(a_out_from_wb, aclk, aresetn, $rose(m_tvalid_reg),
        ($past(state_reg) == S_WB) && $past(emit_reg))
    // A word at a filtering column moves on to the horizontal sum.
    `SBD_ASSERT_NEXT(a_active_to_hsum, aclk, aresetn, s_tvalid && s_tready && active,
        state_reg == S_HSUM)
    // The line store is written only once the sums of this item are complete.
    `SBD_ASSERT_IMPLY(a_write_after_sum, aclk, aresetn, wr_en,
        ($past(state_reg) == S_HSUM) || ($past(state_reg) == S_VSUM)
        || ($past(state_reg) == S_WB))

endmodule
